// ----- design/ttmf_pkg.sv -----
// ----------------------------------------------------------------------------
// ttmf_pkg
// Shared constants, types and the motion curve function for the touchpad filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ttmf_pkg;

  // Field widths
  localparam int unsigned POS_W  = 16;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned BTN_W  = 8;
  localparam int unsigned FING_W = 8;
  localparam int unsigned MOVE_W = 11;

  // Curve: magnitude is saturated at CURVE_MAX_DELTA, then raised to 1.2
  localparam int unsigned CURVE_MAX_DELTA = 255;
  localparam int unsigned CURVE_CLAMP     = 1023;
  localparam int unsigned CURVE_OUT_W     = 10;
  localparam int unsigned LUT_DEPTH       = CURVE_MAX_DELTA + 1;
  localparam int unsigned MAG_W           = $clog2(LUT_DEPTH);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED          = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TAP_ENABLE       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_TAP_ENABLE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS      = CFG_IDX_W'(3);

  localparam logic [TIME_W-1:0] DEBOUNCE_RESET = TIME_W'(100);

  // Request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Button bits set by a tap
  localparam logic [BTN_W-1:0] BTN_TAP_SINGLE = BTN_W'(1);
  localparam logic [BTN_W-1:0] BTN_TAP_MULTI  = BTN_W'(2);

  // Poll classification made by the front
  typedef enum logic [1:0] {
    CLS_NO_REPORT,
    CLS_START,
    CLS_LIFT,
    CLS_MOVE
  } poll_class_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  typedef struct packed {
    logic                     curve;
    logic                     neg_x;
    logic [MAG_W-1:0]         mag_x;
    logic                     neg_y;
    logic [MAG_W-1:0]         mag_y;
    logic signed [MOVE_W-1:0] move_x_in;
    logic signed [MOVE_W-1:0] move_y_in;
    logic [BTN_W-1:0]         buttons;
    logic                     scrolling;
  } motion_req_t;

  // floor(m^1.2) as the largest k with k^5 <= m^6, clamped
  function automatic logic [CURVE_OUT_W-1:0] curve_entry(input int unsigned m);
    longint unsigned   m64;
    longint unsigned   n6;
    longint unsigned   lo;
    longint unsigned   hi;
    longint unsigned   mid;
    longint unsigned   p5;
    m64 = 64'(m);
    n6  = m64 * m64 * m64 * m64 * m64 * m64;
    lo  = 0;
    hi  = 4096;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      p5  = mid * mid * mid * mid * mid;
      if (p5 <= n6) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    if (lo > 64'(CURVE_CLAMP)) begin
      lo = 64'(CURVE_CLAMP);
    end
    return CURVE_OUT_W'(lo);
  endfunction

endpackage

`default_nettype wire

// ----- design/ttmf_if.sv -----
// ----------------------------------------------------------------------------
// ttmf_if
// Valid/ready channels for poll requests and filtered reports.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttmf_poll_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic [ttmf_pkg::POS_W-1:0]         pos_x;
  logic [ttmf_pkg::POS_W-1:0]         pos_y;
  logic                               tip;
  logic [ttmf_pkg::FING_W-1:0]        extra_fingers;
  logic [ttmf_pkg::TIME_W-1:0]        now_ms;
  logic [ttmf_pkg::BTN_W-1:0]         buttons_in;
  logic signed [ttmf_pkg::MOVE_W-1:0] move_x_in;
  logic signed [ttmf_pkg::MOVE_W-1:0] move_y_in;

  modport source (
    output valid, kind, pos_x, pos_y, tip, extra_fingers, now_ms,
           buttons_in, move_x_in, move_y_in,
    input  ready
  );
  modport sink (
    input  valid, kind, pos_x, pos_y, tip, extra_fingers, now_ms,
           buttons_in, move_x_in, move_y_in,
    output ready
  );
endinterface

interface ttmf_report_if;
  logic                               valid;
  logic                               ready;
  logic signed [ttmf_pkg::MOVE_W-1:0] move_x;
  logic signed [ttmf_pkg::MOVE_W-1:0] move_y;
  logic [ttmf_pkg::BTN_W-1:0]         buttons_out;
  logic                               scrolling;

  modport source (
    output valid, move_x, move_y, buttons_out, scrolling,
    input  ready
  );
  modport sink (
    input  valid, move_x, move_y, buttons_out, scrolling,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/ttmf_front.sv -----
// ----------------------------------------------------------------------------
// ttmf_front
// Accepts polls, classifies them against the touch state, updates the state
// and queues a request for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ttmf_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ttmf_pkg::cfg_write_t  cfg,
  ttmf_poll_if.sink                  poll,
  output logic                       push,
  output ttmf_pkg::motion_req_t      push_data,
  input  wire logic                  full
);

  // Configuration
  logic                          enabled;
  logic                          tap_enable;
  logic                          multi_tap_enable;
  logic [ttmf_pkg::TIME_W-1:0]   debounce_ms;

  // Touch state
  logic                          touch_active, touch_active_next;
  logic [ttmf_pkg::POS_W-1:0]    last_x, last_x_next;
  logic [ttmf_pkg::POS_W-1:0]    last_y, last_y_next;
  logic [ttmf_pkg::TIME_W-1:0]   touch_start_ms, touch_start_ms_next;
  logic                          moved, moved_next;
  logic [ttmf_pkg::FING_W-1:0]   last_finger_count, last_finger_count_next;
  logic                          clear_pending, clear_pending_next;
  logic                          scroll_mode, scroll_mode_next;

  ttmf_pkg::poll_class_t         cls;
  logic [ttmf_pkg::TIME_W-1:0]   elapsed;
  logic                          debounced;
  logic                          dx_neg, dy_neg;
  logic [ttmf_pkg::MAG_W-1:0]    dx_mag, dy_mag;

  // Sign and saturated magnitude of a 16-bit wrapped difference
  function automatic logic [ttmf_pkg::MAG_W:0] delta_mag(
    input logic [ttmf_pkg::POS_W-1:0] pos,
    input logic [ttmf_pkg::POS_W-1:0] last
  );
    logic [ttmf_pkg::POS_W-1:0] d;
    logic [ttmf_pkg::POS_W-1:0] a;
    logic [ttmf_pkg::MAG_W-1:0] m;
    d = pos - last;
    a = d[ttmf_pkg::POS_W-1] ? (~d + 1'b1) : d;
    if (a > ttmf_pkg::POS_W'(ttmf_pkg::CURVE_MAX_DELTA)) begin
      m = ttmf_pkg::MAG_W'(ttmf_pkg::CURVE_MAX_DELTA);
    end else begin
      m = a[ttmf_pkg::MAG_W-1:0];
    end
    return {d[ttmf_pkg::POS_W-1], m};
  endfunction

  assign poll.ready = !full;
  assign push       = poll.valid && !full;

  assign elapsed    = poll.now_ms - touch_start_ms;
  assign debounced  = elapsed >= debounce_ms;
  assign {dx_neg, dx_mag} = delta_mag(poll.pos_x, last_x);
  assign {dy_neg, dy_mag} = delta_mag(poll.pos_y, last_y);

  always_comb begin
    if (!poll.kind || !enabled) begin
      cls = ttmf_pkg::CLS_NO_REPORT;
    end else if (!touch_active && poll.tip) begin
      cls = ttmf_pkg::CLS_START;
    end else if (!poll.tip) begin
      cls = ttmf_pkg::CLS_LIFT;
    end else begin
      cls = ttmf_pkg::CLS_MOVE;
    end
  end

  always_comb begin
    touch_active_next      = touch_active;
    last_x_next            = last_x;
    last_y_next            = last_y;
    touch_start_ms_next    = touch_start_ms;
    moved_next             = moved;
    last_finger_count_next = last_finger_count;
    clear_pending_next     = clear_pending;
    scroll_mode_next       = scroll_mode;

    push_data.curve     = 1'b0;
    push_data.neg_x     = dx_neg;
    push_data.mag_x     = dx_mag;
    push_data.neg_y     = dy_neg;
    push_data.mag_y     = dy_mag;
    push_data.move_x_in = poll.move_x_in;
    push_data.move_y_in = poll.move_y_in;
    push_data.buttons   = poll.buttons_in;

    case (cls)
      ttmf_pkg::CLS_NO_REPORT: begin
        if (clear_pending) begin
          clear_pending_next = 1'b0;
          push_data.buttons  = '0;
        end
      end
      ttmf_pkg::CLS_START: begin
        last_x_next         = poll.pos_x;
        last_y_next         = poll.pos_y;
        touch_active_next   = 1'b1;
        touch_start_ms_next = poll.now_ms;
        moved_next          = 1'b0;
      end
      ttmf_pkg::CLS_LIFT: begin
        touch_active_next = 1'b0;
        // lift without motion is a tap; the buttons are cleared later
        if (!moved) begin
          if (last_finger_count != '0) begin
            if (multi_tap_enable) begin
              push_data.buttons = poll.buttons_in | ttmf_pkg::BTN_TAP_MULTI;
            end
          end else if (tap_enable) begin
            push_data.buttons = poll.buttons_in | ttmf_pkg::BTN_TAP_SINGLE;
          end
          clear_pending_next = 1'b1;
        end
        scroll_mode_next = 1'b0;
      end
      ttmf_pkg::CLS_MOVE: begin
        if (debounced) begin
          if (poll.extra_fingers != '0) begin
            scroll_mode_next = 1'b1;
          end
          push_data.curve = 1'b1;
          last_x_next     = poll.pos_x;
          last_y_next     = poll.pos_y;
          moved_next      = 1'b1;
        end
        last_finger_count_next = poll.extra_fingers;
      end
      default: begin
      end
    endcase

    push_data.scrolling = scroll_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled          <= 1'b0;
      tap_enable       <= 1'b1;
      multi_tap_enable <= 1'b0;
      debounce_ms      <= ttmf_pkg::DEBOUNCE_RESET;
    end else if (cfg.we) begin
      case (cfg.idx)
        ttmf_pkg::REG_ENABLED:          enabled          <= cfg.data[0];
        ttmf_pkg::REG_TAP_ENABLE:       tap_enable       <= cfg.data[0];
        ttmf_pkg::REG_MULTI_TAP_ENABLE: multi_tap_enable <= cfg.data[0];
        ttmf_pkg::REG_DEBOUNCE_MS: begin
          debounce_ms <= cfg.data[ttmf_pkg::TIME_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      touch_active      <= 1'b0;
      last_x            <= '0;
      last_y            <= '0;
      touch_start_ms    <= '0;
      moved             <= 1'b0;
      last_finger_count <= '0;
      clear_pending     <= 1'b0;
      scroll_mode       <= 1'b0;
    end else if (push) begin
      touch_active      <= touch_active_next;
      last_x            <= last_x_next;
      last_y            <= last_y_next;
      touch_start_ms    <= touch_start_ms_next;
      moved             <= moved_next;
      last_finger_count <= last_finger_count_next;
      clear_pending     <= clear_pending_next;
      scroll_mode       <= scroll_mode_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/ttmf_queue.sv -----
// ----------------------------------------------------------------------------
// ttmf_queue
// Short request queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ttmf_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire ttmf_pkg::motion_req_t push_data,
  output logic                       full,
  input  wire logic                  pop,
  output ttmf_pkg::motion_req_t      pop_data,
  output logic                       empty
);

  ttmf_pkg::motion_req_t                slots [ttmf_pkg::QUEUE_DEPTH];
  logic [ttmf_pkg::QUEUE_PTR_W-1:0]     wr_ptr, wr_ptr_next;
  logic [ttmf_pkg::QUEUE_PTR_W-1:0]     rd_ptr, rd_ptr_next;
  logic [ttmf_pkg::QUEUE_CNT_W-1:0]     count;

  localparam logic [ttmf_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
    ttmf_pkg::QUEUE_PTR_W'(ttmf_pkg::QUEUE_DEPTH - 1);

  assign full     = count == ttmf_pkg::QUEUE_CNT_W'(ttmf_pkg::QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = slots[rd_ptr];

  assign wr_ptr_next = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ttmf_pkg::QUEUE_CNT_W'(ttmf_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("request pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("request popped from empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == ttmf_pkg::QUEUE_CNT_W'($past(count) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

`default_nettype wire

// ----- design/ttmf_back.sv -----
// ----------------------------------------------------------------------------
// ttmf_back
// Applies the motion curve to queued requests that ask for it and holds the report register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttmf_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  empty,
  input  wire ttmf_pkg::motion_req_t pop_data,
  output logic                       pop,
  ttmf_report_if.source              report
);

  logic                                 out_valid;
  logic signed [ttmf_pkg::MOVE_W-1:0]   move_x, move_y;
  logic [ttmf_pkg::BTN_W-1:0]           buttons_out;
  logic                                 scrolling;
  logic signed [ttmf_pkg::MOVE_W-1:0]   curve_x, curve_y;
  logic [ttmf_pkg::CURVE_OUT_W-1:0]     curve_lut [ttmf_pkg::LUT_DEPTH];

  function automatic logic [ttmf_pkg::MOVE_W-1:0] apply_curve(
    input logic                             neg,
    input logic [ttmf_pkg::CURVE_OUT_W-1:0] val
  );
    logic [ttmf_pkg::MOVE_W-1:0] u;
    u = ttmf_pkg::MOVE_W'(val);
    return neg ? (~u + 1'b1) : u;
  endfunction

  // constant curve table, one entry per saturated magnitude
  for (genvar i = 0; i < ttmf_pkg::LUT_DEPTH; i++) begin : g_curve_lut
    localparam logic [ttmf_pkg::CURVE_OUT_W-1:0] ENTRY = ttmf_pkg::curve_entry(i);
    assign curve_lut[i] = ENTRY;
  end

  assign curve_x = apply_curve(pop_data.neg_x, curve_lut[pop_data.mag_x]);
  assign curve_y = apply_curve(pop_data.neg_y, curve_lut[pop_data.mag_y]);

  assign pop = !empty && (!out_valid || report.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      move_x      <= pop_data.curve ? curve_x : pop_data.move_x_in;
      move_y      <= pop_data.curve ? curve_y : pop_data.move_y_in;
      buttons_out <= pop_data.buttons;
      scrolling   <= pop_data.scrolling;
    end
  end

  assign report.valid       = out_valid;
  assign report.move_x      = move_x;
  assign report.move_y      = move_y;
  assign report.buttons_out = buttons_out;
  assign report.scrolling   = scrolling;

endmodule

`default_nettype wire

// ----- design/touchpad_tap_and_motion_filter.sv -----
// ----------------------------------------------------------------------------
// touchpad_tap_and_motion_filter
// Tap detection and curved motion for absolute touchpad reports.
// ----------------------------------------------------------------------------
// Usage:
//   poll   - one request per host poll, with or without a fresh touch report.
//   report - exactly one result per poll: motion, buttons and scroll flag.
//   cfg_we/cfg_idx/cfg_data - register writes, only while the block is idle.
// Timing:
//   An accepted poll passes through the request queue and then the report
//   register. One poll per cycle is sustained while report is not stalled;
//   each poll is classified and the touch state updated by the front, and
//   the back does the curve lookup and loads the report register.
// Reset:
//   Clears the touch state, the request queue and the report valid flag, and
//   loads the register defaults (disabled, tap on, multi-tap off, 100 ms).
// Stall:
//   While report is stalled the report register holds; up to two requests
//   wait in the queue, after which poll.ready drops until one drains.
// ----------------------------------------------------------------------------
`default_nettype none

module touchpad_tap_and_motion_filter (
  input  wire logic                              clk,
  input  wire logic                              rst,
  ttmf_poll_if.sink                              poll,
  ttmf_report_if.source                          report,
  input  wire logic                              cfg_we,
  input  wire logic [ttmf_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [ttmf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  ttmf_pkg::cfg_write_t   cfg;
  ttmf_pkg::motion_req_t  push_data;
  ttmf_pkg::motion_req_t  pop_data;
  logic                   push, pop, full, empty;

  assign cfg.we   = cfg_we;
  assign cfg.idx  = cfg_idx;
  assign cfg.data = cfg_data;

  ttmf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .poll      (poll),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  ttmf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  ttmf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop_data (pop_data),
    .pop      (pop),
    .report   (report)
  );

endmodule

`default_nettype wire
